>>> rtl/ptw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_pkg
// Types, constants and codes shared by the periodic timer wheel modules.
// ----------------------------------------------------------------------------
package ptw_pkg;

    localparam int MAX_TIMERS  = 32;
    localparam int ROOT_BITS   = 8;
    localparam int LEVEL_BITS  = 6;

    localparam int ROOT_SIZE   = 1 << ROOT_BITS;
    localparam int LVL_SIZE    = 1 << LEVEL_BITS;
    localparam int NUM_BUCKETS = ROOT_SIZE + 4 * LVL_SIZE;
    localparam int BKT_AW      = $clog2(NUM_BUCKETS);
    localparam int SLOT_W      = $clog2(MAX_TIMERS);
    localparam int FAR_BITS    = ROOT_BITS + 4 * LEVEL_BITS;
    localparam logic [31:0] MAX_DIST = 32'((33'd1 << FAR_BITS) - 33'd1);

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_REFUSED   = 3'd1;
    localparam logic [2:0] KIND_REMOVED   = 3'd2;
    localparam logic [2:0] KIND_NOTFOUND  = 3'd3;
    localparam logic [2:0] KIND_FIRED     = 3'd4;
    localparam logic [2:0] KIND_TICK_DONE = 3'd5;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [30:0] interval;
        logic [31:0] user_tag;
        logic [31:0] timer_id;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] result_id;
        logic [31:0] result_tag;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
    } bkt_t;

    typedef struct packed {
        logic [31:0] ident;
        logic [31:0] tag;
        logic [30:0] period;
    } info_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_TAKE,
        OP_ALLOC,
        OP_SCAN_RD,
        OP_SCAN_CMP,
        OP_LOC_RD,
        OP_RM_BKT_RD,
        OP_RM_HEAD,
        OP_RM_NEWHEAD,
        OP_RM_WALK,
        OP_RM_SPLICE,
        OP_RM_FREE,
        OP_TICK_START,
        OP_CS_ADDR,
        OP_ADV,
        OP_BK_RD,
        OP_DRAIN_START,
        OP_NODE_RD,
        OP_NODE_CASC,
        OP_NODE_TICK,
        OP_PL_RD,
        OP_PL_WR,
        OP_LVL_INC,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] kind;
        logic       last;
    } ctl_t;

    typedef struct packed {
        logic clr_done;
        logic full;
        logic scan_hit;
        logic scan_end;
        logic bk_valid;
        logic bk_hd_cur;
        logic bk_tl_cur;
        logic lk_cur;
        logic root_zero;
        logic lvl_idx_zero;
        logic lvl_last;
        logic node_last;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

>>> rtl/periodic_timer_wheel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_timer_wheel
// Five-level cascading wheel of periodic timers with FIFO buckets.
// ----------------------------------------------------------------------------
// Input channel cmd_valid / cmd_stall / cmd_word carries one command word:
// tick, add (interval, user_tag) or remove (timer_id). Output channel
// res_valid / res_stall / res_word returns the results; the final word for a
// command has last set. A tick returns one fired word per expired timer and
// then a tick done word.
// One command is worked at a time by a sequencer over single-port memories.
// Work done per command once accepted:
//   add      allocates a slot and places the timer (no placement when refused)
//   remove   searches the slots (at most 32), then unlinks the timer: the
//            head moves, or the list is walked and the entry spliced out
//   tick     visits cascade levels, moves timers down and fires timers
// cmd_stall is low only while the block waits for the next command.
// After reset a clearing pass empties every bucket of the table; the
// command channel stays stalled meanwhile. A stalled result word is held in
// the output register and the sequencer waits until it can load the next.
// ----------------------------------------------------------------------------
module periodic_timer_wheel (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    output logic                cmd_stall,
    input  ptw_pkg::in_word_t   cmd_word,
    output logic                res_valid,
    input  wire                 res_stall,
    output ptw_pkg::out_word_t  res_word
);

    ptw_pkg::ctl_t  ctl;
    ptw_pkg::stat_t stat;

    ptw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_code  (cmd_word.cmd),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    ptw_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cmd_word  (cmd_word),
        .stat      (stat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

endmodule
`default_nettype wire

>>> rtl/ptw_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_dp
// Datapath: bucket, slot and link memories, wheel time, id counter, placement
// and the result register.
// ----------------------------------------------------------------------------
module ptw_dp (
    input  wire                 clk,
    input  wire                 rst_n,
    input  ptw_pkg::ctl_t       ctl,
    input  ptw_pkg::in_word_t   cmd_word,
    output ptw_pkg::stat_t      stat,
    output logic                res_valid,
    input  wire                 res_stall,
    output ptw_pkg::out_word_t  res_word
);

    localparam int SW = ptw_pkg::SLOT_W;
    localparam int BW = ptw_pkg::BKT_AW;
    localparam int RB = ptw_pkg::ROOT_BITS;
    localparam int LB = ptw_pkg::LEVEL_BITS;

    ptw_pkg::bkt_t  bkt_mem [ptw_pkg::NUM_BUCKETS];
    ptw_pkg::info_t info_mem [ptw_pkg::MAX_TIMERS];
    logic [31:0]    exp_mem [ptw_pkg::MAX_TIMERS];
    logic [SW-1:0]  link_mem [ptw_pkg::MAX_TIMERS];
    logic [BW-1:0]  loc_mem [ptw_pkg::MAX_TIMERS];

    ptw_pkg::bkt_t  bk_q;
    ptw_pkg::info_t info_q;
    logic [31:0]    exp_q;
    logic [SW-1:0]  link_q;
    logic [BW-1:0]  loc_q;

    logic                          bk_re, bk_we;
    logic [BW-1:0]                 bk_ra, bk_wa;
    ptw_pkg::bkt_t                 bk_wd;
    logic                          lk_re, lk_we;
    logic [SW-1:0]                 lk_ra, lk_wa, lk_wd;
    logic                          inf_re, inf_we;
    logic [SW-1:0]                 inf_ra, inf_wa;
    ptw_pkg::info_t                inf_wd;
    logic                          ex_re, ex_we;
    logic [SW-1:0]                 ex_ra, ex_wa;
    logic [31:0]                   ex_wd;
    logic                          lc_re, lc_we;
    logic [SW-1:0]                 lc_ra, lc_wa;
    logic [BW-1:0]                 lc_wd;

    logic [31:0]                   wt_reg, nid_reg;
    logic [ptw_pkg::MAX_TIMERS-1:0] used_reg;
    logic [BW-1:0]                 clr_reg;
    logic                          out_valid_reg;
    ptw_pkg::out_word_t            out_reg;
    ptw_pkg::in_word_t             in_reg;
    logic [SW-1:0]                 cur_reg, nxt_reg, tl_reg, hd_reg, prev_reg, k_reg;
    logic [BW-1:0]                 bidx_reg, pb_reg;
    logic [1:0]                    lvl_reg;
    logic [31:0]                   e_reg, res_id_reg;

    logic [SW-1:0]                 free_idx;
    logic [BW-1:0]                 pl_bkt, cs_bkt;
    logic [LB-1:0]                 cs_idx;
    logic [31:0]                   delta, far_e, alloc_e, tick_e;
    logic                          out_free;

    // first free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = ptw_pkg::MAX_TIMERS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = SW'(i);
            end
        end
    end

    // cascade bucket of the current level
    always_comb
    begin
        case (lvl_reg)
            2'd0:    cs_idx = wt_reg[RB +: LB];
            2'd1:    cs_idx = wt_reg[RB + LB +: LB];
            2'd2:    cs_idx = wt_reg[RB + 2 * LB +: LB];
            default: cs_idx = wt_reg[RB + 3 * LB +: LB];
        endcase
        cs_bkt = BW'(ptw_pkg::ROOT_SIZE) + BW'({lvl_reg, cs_idx});
    end

    // bucket for expiry e_reg
    always_comb
    begin
        delta = e_reg - wt_reg;
        far_e = ((delta >> ptw_pkg::FAR_BITS) != 32'd0) ? wt_reg + ptw_pkg::MAX_DIST : e_reg;
        if ((delta >> RB) == 32'd0)
        begin
            pl_bkt = BW'(e_reg[RB-1:0]);
        end
        else if ((delta >> (RB + LB)) == 32'd0)
        begin
            pl_bkt = BW'(ptw_pkg::ROOT_SIZE) + BW'({2'd0, e_reg[RB +: LB]});
        end
        else if ((delta >> (RB + 2 * LB)) == 32'd0)
        begin
            pl_bkt = BW'(ptw_pkg::ROOT_SIZE) + BW'({2'd1, e_reg[RB + LB +: LB]});
        end
        else if ((delta >> (RB + 3 * LB)) == 32'd0)
        begin
            pl_bkt = BW'(ptw_pkg::ROOT_SIZE) + BW'({2'd2, e_reg[RB + 2 * LB +: LB]});
        end
        else if (delta[31])
        begin
            pl_bkt = BW'(wt_reg[RB-1:0]);
        end
        else
        begin
            pl_bkt = BW'(ptw_pkg::ROOT_SIZE) + BW'({2'd3, far_e[RB + 3 * LB +: LB]});
        end
    end

    assign alloc_e  = wt_reg + {1'b0, in_reg.interval};
    assign tick_e   = exp_q + {1'b0, info_q.period};
    assign out_free = !out_valid_reg || !res_stall;

    // memory port control
    always_comb
    begin
        bk_re  = 1'b0; bk_ra = '0; bk_we = 1'b0; bk_wa = '0; bk_wd = '0;
        lk_re  = 1'b0; lk_ra = '0; lk_we = 1'b0; lk_wa = '0; lk_wd = '0;
        inf_re = 1'b0; inf_ra = '0; inf_we = 1'b0; inf_wa = '0; inf_wd = '0;
        ex_re  = 1'b0; ex_ra = '0; ex_we = 1'b0; ex_wa = '0; ex_wd = '0;
        lc_re  = 1'b0; lc_ra = '0; lc_we = 1'b0; lc_wa = '0; lc_wd = '0;
        unique case (ctl.op)
            ptw_pkg::OP_CLEAR:
            begin
                bk_we = 1'b1;
                bk_wa = clr_reg;
            end
            ptw_pkg::OP_ALLOC:
            begin
                if (!(&used_reg))
                begin
                    inf_we = 1'b1;
                    inf_wa = free_idx;
                    inf_wd = '{ident: nid_reg, tag: in_reg.user_tag,
                               period: in_reg.interval};
                    ex_we  = 1'b1;
                    ex_wa  = free_idx;
                    ex_wd  = alloc_e;
                end
            end
            ptw_pkg::OP_SCAN_RD:
            begin
                inf_re = 1'b1;
                inf_ra = k_reg;
            end
            ptw_pkg::OP_LOC_RD:
            begin
                lc_re = 1'b1;
                lc_ra = cur_reg;
            end
            ptw_pkg::OP_RM_BKT_RD:
            begin
                bk_re = 1'b1;
                bk_ra = loc_q;
            end
            ptw_pkg::OP_RM_HEAD:
            begin
                lk_re = 1'b1;
                lk_ra = bk_q.head;
                if (bk_q.head == cur_reg && bk_q.tail == cur_reg)
                begin
                    bk_we = 1'b1;
                    bk_wa = bidx_reg;
                end
            end
            ptw_pkg::OP_RM_NEWHEAD:
            begin
                bk_we = 1'b1;
                bk_wa = bidx_reg;
                bk_wd = '{valid: 1'b1, head: link_q, tail: tl_reg};
            end
            ptw_pkg::OP_RM_WALK:
            begin
                lk_re = 1'b1;
                lk_ra = link_q;
            end
            ptw_pkg::OP_RM_SPLICE:
            begin
                lk_we = 1'b1;
                lk_wa = prev_reg;
                lk_wd = link_q;
                if (tl_reg == cur_reg)
                begin
                    bk_we = 1'b1;
                    bk_wa = bidx_reg;
                    bk_wd = '{valid: 1'b1, head: hd_reg, tail: prev_reg};
                end
            end
            ptw_pkg::OP_BK_RD:
            begin
                bk_re = 1'b1;
                bk_ra = bidx_reg;
            end
            ptw_pkg::OP_DRAIN_START:
            begin
                if (bk_q.valid)
                begin
                    bk_we = 1'b1;
                    bk_wa = bidx_reg;
                end
            end
            ptw_pkg::OP_NODE_RD:
            begin
                lk_re  = 1'b1;
                lk_ra  = cur_reg;
                ex_re  = 1'b1;
                ex_ra  = cur_reg;
                inf_re = 1'b1;
                inf_ra = cur_reg;
            end
            ptw_pkg::OP_NODE_TICK:
            begin
                ex_we = 1'b1;
                ex_wa = cur_reg;
                ex_wd = tick_e;
            end
            ptw_pkg::OP_PL_RD:
            begin
                bk_re = 1'b1;
                bk_ra = pl_bkt;
                lc_we = 1'b1;
                lc_wa = cur_reg;
                lc_wd = pl_bkt;
            end
            ptw_pkg::OP_PL_WR:
            begin
                if (bk_q.valid)
                begin
                    lk_we = 1'b1;
                    lk_wa = bk_q.tail;
                    lk_wd = cur_reg;
                end
                bk_we = 1'b1;
                bk_wa = pb_reg;
                bk_wd = '{valid: 1'b1, head: bk_q.valid ? bk_q.head : cur_reg,
                          tail: cur_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (bk_we)
        begin
            bkt_mem[bk_wa] <= bk_wd;
        end
        if (bk_re)
        begin
            bk_q <= bkt_mem[bk_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lk_we)
        begin
            link_mem[lk_wa] <= lk_wd;
        end
        if (lk_re)
        begin
            link_q <= link_mem[lk_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (inf_we)
        begin
            info_mem[inf_wa] <= inf_wd;
        end
        if (inf_re)
        begin
            info_q <= info_mem[inf_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ex_we)
        begin
            exp_mem[ex_wa] <= ex_wd;
        end
        if (ex_re)
        begin
            exp_q <= exp_mem[ex_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lc_we)
        begin
            loc_mem[lc_wa] <= lc_wd;
        end
        if (lc_re)
        begin
            loc_q <= loc_mem[lc_ra];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wt_reg        <= '0;
            nid_reg       <= '0;
            used_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.op == ptw_pkg::OP_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (ctl.op == ptw_pkg::OP_ALLOC && !(&used_reg))
            begin
                used_reg[free_idx] <= 1'b1;
                nid_reg            <= nid_reg + 32'd1;
            end
            if (ctl.op == ptw_pkg::OP_RM_FREE)
            begin
                used_reg[cur_reg] <= 1'b0;
            end
            if (ctl.op == ptw_pkg::OP_ADV)
            begin
                wt_reg <= wt_reg + 32'd1;
            end
            if (ctl.op == ptw_pkg::OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (ctl.op)
            ptw_pkg::OP_TAKE:
            begin
                in_reg     <= cmd_word;
                k_reg      <= '0;
                res_id_reg <= cmd_word.timer_id;
            end
            ptw_pkg::OP_ALLOC:
            begin
                cur_reg    <= free_idx;
                e_reg      <= alloc_e;
                res_id_reg <= (&used_reg) ? 32'd0 : nid_reg;
            end
            ptw_pkg::OP_SCAN_CMP:
            begin
                if (stat.scan_hit)
                begin
                    cur_reg <= k_reg;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            ptw_pkg::OP_RM_BKT_RD:
            begin
                bidx_reg <= loc_q;
            end
            ptw_pkg::OP_RM_HEAD:
            begin
                hd_reg   <= bk_q.head;
                tl_reg   <= bk_q.tail;
                prev_reg <= bk_q.head;
            end
            ptw_pkg::OP_RM_WALK:
            begin
                if (link_q != cur_reg)
                begin
                    prev_reg <= link_q;
                end
            end
            ptw_pkg::OP_TICK_START:
            begin
                lvl_reg <= '0;
            end
            ptw_pkg::OP_CS_ADDR:
            begin
                bidx_reg <= cs_bkt;
            end
            ptw_pkg::OP_ADV:
            begin
                bidx_reg <= BW'(wt_reg[RB-1:0]);
            end
            ptw_pkg::OP_DRAIN_START:
            begin
                cur_reg <= bk_q.head;
                tl_reg  <= bk_q.tail;
            end
            ptw_pkg::OP_NODE_CASC:
            begin
                nxt_reg <= link_q;
                e_reg   <= exp_q;
            end
            ptw_pkg::OP_NODE_TICK:
            begin
                nxt_reg <= link_q;
                e_reg   <= tick_e;
            end
            ptw_pkg::OP_PL_RD:
            begin
                pb_reg <= pl_bkt;
            end
            ptw_pkg::OP_PL_WR:
            begin
                cur_reg <= nxt_reg;
            end
            ptw_pkg::OP_LVL_INC:
            begin
                lvl_reg <= lvl_reg + 2'd1;
            end
            ptw_pkg::OP_EMIT:
            begin
                out_reg.kind <= ctl.kind;
                out_reg.last <= ctl.last;
                if (ctl.kind == ptw_pkg::KIND_FIRED)
                begin
                    out_reg.result_id  <= info_q.ident;
                    out_reg.result_tag <= info_q.tag;
                end
                else if (ctl.kind == ptw_pkg::KIND_ADDED || ctl.kind == ptw_pkg::KIND_REMOVED
                         || ctl.kind == ptw_pkg::KIND_NOTFOUND)
                begin
                    out_reg.result_id  <= res_id_reg;
                    out_reg.result_tag <= '0;
                end
                else
                begin
                    out_reg.result_id  <= '0;
                    out_reg.result_tag <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat.clr_done     = (clr_reg == BW'(ptw_pkg::NUM_BUCKETS - 1));
        stat.full         = &used_reg;
        stat.scan_hit     = used_reg[k_reg] && (info_q.ident == in_reg.timer_id);
        stat.scan_end     = (k_reg == SW'(ptw_pkg::MAX_TIMERS - 1));
        stat.bk_valid     = bk_q.valid;
        stat.bk_hd_cur    = (bk_q.head == cur_reg);
        stat.bk_tl_cur    = (bk_q.tail == cur_reg);
        stat.lk_cur       = (link_q == cur_reg);
        stat.root_zero    = (wt_reg[RB-1:0] == '0);
        stat.lvl_idx_zero = (cs_idx == '0);
        stat.lvl_last     = (lvl_reg == 2'd3);
        stat.node_last    = (cur_reg == tl_reg);
        stat.out_free     = out_free;
    end

    assign res_valid = out_valid_reg;
    assign res_word  = out_reg;

`ifndef SYNTH
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == ptw_pkg::OP_EMIT) |-> out_free)
        else $error("result loaded over a held word");
    a_free_used: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == ptw_pkg::OP_RM_FREE) |-> used_reg[cur_reg])
        else $error("freeing a slot that is not in use");
    a_wt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (wt_reg != $past(wt_reg)) |-> ($past(ctl.op) == ptw_pkg::OP_ADV))
        else $error("wheel time moved outside a tick");
`endif

endmodule
`default_nettype wire

>>> rtl/ptw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_ctrl
// Sequencer for add, remove and tick: issues datapath operations and walks
// cascades, bucket lists and placements.
// ----------------------------------------------------------------------------
module ptw_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               cmd_valid,
    input  wire  [1:0]        cmd_code,
    output logic              cmd_stall,
    input  ptw_pkg::stat_t    stat,
    output ptw_pkg::ctl_t     ctl
);

    typedef enum logic [23:0] {
        S_CLR        = 24'h000001,
        S_IDLE       = 24'h000002,
        S_ADD        = 24'h000004,
        S_SCAN_RD    = 24'h000008,
        S_SCAN_CMP   = 24'h000010,
        S_RM_LOC     = 24'h000020,
        S_RM_BKT     = 24'h000040,
        S_RM_HEAD    = 24'h000080,
        S_RM_NEWHEAD = 24'h000100,
        S_RM_WALK    = 24'h000200,
        S_RM_SPLICE  = 24'h000400,
        S_RM_FREE    = 24'h000800,
        S_TICK       = 24'h001000,
        S_CS_RD      = 24'h002000,
        S_T_ADV      = 24'h004000,
        S_BK_RD      = 24'h008000,
        S_BK_CHK     = 24'h010000,
        S_DR_RD      = 24'h020000,
        S_DR_NODE    = 24'h040000,
        S_DR_FIRE    = 24'h080000,
        S_PL_RD      = 24'h100000,
        S_PL_WR      = 24'h200000,
        S_DR_END     = 24'h400000,
        S_EMIT       = 24'h800000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] kind_reg, kind_next;
    logic       tick_reg, tick_next;
    logic       drain_reg, drain_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            kind_reg  <= ptw_pkg::KIND_TICK_DONE;
            tick_reg  <= 1'b0;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            tick_reg  <= tick_next;
            drain_reg <= drain_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        tick_next  = tick_reg;
        drain_next = drain_reg;
        ctl.op     = ptw_pkg::OP_NONE;
        ctl.kind   = kind_reg;
        ctl.last   = 1'b1;
        cmd_stall  = (state_reg != S_IDLE);
        unique case (state_reg)
            S_CLR:
            begin
                ctl.op = ptw_pkg::OP_CLEAR;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.op = ptw_pkg::OP_TAKE;
                    case (cmd_code)
                        ptw_pkg::CMD_ADD:    state_next = S_ADD;
                        ptw_pkg::CMD_REMOVE: state_next = S_SCAN_RD;
                        ptw_pkg::CMD_TICK:   state_next = S_TICK;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD:
            begin
                ctl.op     = ptw_pkg::OP_ALLOC;
                drain_next = 1'b0;
                if (stat.full)
                begin
                    kind_next  = ptw_pkg::KIND_REFUSED;
                    state_next = S_EMIT;
                end
                else
                begin
                    kind_next  = ptw_pkg::KIND_ADDED;
                    state_next = S_PL_RD;
                end
            end
            S_SCAN_RD:
            begin
                ctl.op     = ptw_pkg::OP_SCAN_RD;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                ctl.op = ptw_pkg::OP_SCAN_CMP;
                if (stat.scan_hit)
                begin
                    state_next = S_RM_LOC;
                end
                else if (stat.scan_end)
                begin
                    kind_next  = ptw_pkg::KIND_NOTFOUND;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_RM_LOC:
            begin
                ctl.op     = ptw_pkg::OP_LOC_RD;
                state_next = S_RM_BKT;
            end
            S_RM_BKT:
            begin
                ctl.op     = ptw_pkg::OP_RM_BKT_RD;
                state_next = S_RM_HEAD;
            end
            S_RM_HEAD:
            begin
                ctl.op = ptw_pkg::OP_RM_HEAD;
                if (stat.bk_hd_cur && stat.bk_tl_cur)
                begin
                    state_next = S_RM_FREE;
                end
                else if (stat.bk_hd_cur)
                begin
                    state_next = S_RM_NEWHEAD;
                end
                else
                begin
                    state_next = S_RM_WALK;
                end
            end
            S_RM_NEWHEAD:
            begin
                ctl.op     = ptw_pkg::OP_RM_NEWHEAD;
                state_next = S_RM_FREE;
            end
            S_RM_WALK:
            begin
                ctl.op = ptw_pkg::OP_RM_WALK;
                if (stat.lk_cur)
                begin
                    state_next = S_RM_SPLICE;
                end
            end
            S_RM_SPLICE:
            begin
                ctl.op     = ptw_pkg::OP_RM_SPLICE;
                state_next = S_RM_FREE;
            end
            S_RM_FREE:
            begin
                ctl.op     = ptw_pkg::OP_RM_FREE;
                kind_next  = ptw_pkg::KIND_REMOVED;
                state_next = S_EMIT;
            end
            S_TICK:
            begin
                ctl.op     = ptw_pkg::OP_TICK_START;
                state_next = stat.root_zero ? S_CS_RD : S_T_ADV;
            end
            S_CS_RD:
            begin
                ctl.op     = ptw_pkg::OP_CS_ADDR;
                tick_next  = 1'b0;
                state_next = S_BK_RD;
            end
            S_T_ADV:
            begin
                ctl.op     = ptw_pkg::OP_ADV;
                tick_next  = 1'b1;
                state_next = S_BK_RD;
            end
            S_BK_RD:
            begin
                ctl.op     = ptw_pkg::OP_BK_RD;
                state_next = S_BK_CHK;
            end
            S_BK_CHK:
            begin
                ctl.op     = ptw_pkg::OP_DRAIN_START;
                state_next = stat.bk_valid ? S_DR_RD : S_DR_END;
            end
            S_DR_RD:
            begin
                ctl.op     = ptw_pkg::OP_NODE_RD;
                state_next = S_DR_NODE;
            end
            S_DR_NODE:
            begin
                ctl.op     = tick_reg ? ptw_pkg::OP_NODE_TICK : ptw_pkg::OP_NODE_CASC;
                drain_next = 1'b1;
                state_next = tick_reg ? S_DR_FIRE : S_PL_RD;
            end
            S_DR_FIRE:
            begin
                ctl.kind = ptw_pkg::KIND_FIRED;
                ctl.last = 1'b0;
                if (stat.out_free)
                begin
                    ctl.op     = ptw_pkg::OP_EMIT;
                    state_next = S_PL_RD;
                end
            end
            S_PL_RD:
            begin
                ctl.op     = ptw_pkg::OP_PL_RD;
                state_next = S_PL_WR;
            end
            S_PL_WR:
            begin
                ctl.op = ptw_pkg::OP_PL_WR;
                if (!drain_reg)
                begin
                    state_next = S_EMIT;
                end
                else if (stat.node_last)
                begin
                    state_next = S_DR_END;
                end
                else
                begin
                    state_next = S_DR_RD;
                end
            end
            S_DR_END:
            begin
                if (tick_reg)
                begin
                    kind_next  = ptw_pkg::KIND_TICK_DONE;
                    state_next = S_EMIT;
                end
                else if (stat.lvl_idx_zero && !stat.lvl_last)
                begin
                    ctl.op     = ptw_pkg::OP_LVL_INC;
                    state_next = S_CS_RD;
                end
                else
                begin
                    state_next = S_T_ADV;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.op     = ptw_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op != ptw_pkg::OP_TAKE && ctl.op != ptw_pkg::OP_NONE) |-> cmd_stall)
        else $error("datapath busy while accepting words");
    a_fire_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == ptw_pkg::OP_EMIT && ctl.kind == ptw_pkg::KIND_FIRED) |-> tick_reg)
        else $error("fired word outside a root drain");
    a_clr_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLR) |=> (state_reg != S_CLR))
        else $error("clearing pass restarted");
`endif

endmodule
`default_nettype wire
